>>> hdl/pli_pkg.sv
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int VAL_W      = 32;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int STAT_W     = 2;
    localparam int QDEPTH     = 2;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DIV = 2'd2;

    // One query handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic signed [VAL_W-1:0] q;
        logic signed [VAL_W-1:0] x0;
        logic signed [VAL_W-1:0] x1;
        logic signed [VAL_W-1:0] y0;
        logic signed [VAL_W-1:0] y1;
    } seg_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SCAN,
        FE_FETCH,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL,
        BE_DIV,
        BE_ROUND,
        BE_OUT
    } be_state_t;

endpackage

>>> hdl/pli_front.sv
module pli_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_mode,
    input  logic [pli_pkg::IDX_W-1:0]           in_index,
    input  logic [pli_pkg::VAL_W-1:0]           in_px,
    input  logic [pli_pkg::VAL_W-1:0]           in_py,
    input  logic [pli_pkg::VAL_W-1:0]           in_qx,
    input  logic [pli_pkg::CNT_W-1:0]           points,
    output logic                                seg_valid,
    input  logic                                seg_ready,
    output pli_pkg::seg_t                       seg
);
    import pli_pkg::*;

    logic [VAL_W-1:0] xmem [MAX_POINTS];
    logic [VAL_W-1:0] ymem [MAX_POINTS];

    fe_state_t              state_reg, state_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic signed [VAL_W-1:0] q_reg, q_next;
    logic [IDX_W-1:0]       rd_addr;
    logic [VAL_W-1:0]       xrd, yrd;
    logic                   fetch1_reg, fetch1_next;
    seg_t                   seg_reg, seg_next;
    logic [CNT_W-1:0]       nclamp;
    logic                   last_k;

    // Clamp the point count to the table range.
    always_comb
    begin
        if (points < CNT_W'(2))
            nclamp = CNT_W'(2);
        else if (points > CNT_W'(MAX_POINTS))
            nclamp = CNT_W'(MAX_POINTS);
        else
            nclamp = points;
    end

    // Breakpoint memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && !in_mode)
        begin
            xmem[in_index] <= in_px;
            ymem[in_index] <= in_py;
        end
        xrd <= xmem[rd_addr];
        yrd <= ymem[rd_addr];
    end

    assign last_k = ({1'b0, k_reg} == n_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        n_reg      <= n_next;
        q_reg      <= q_next;
        fetch1_reg <= fetch1_next;
        seg_reg    <= seg_next;
    end

    // Scan compares x[k] before reading x[k+1]; read data is registered.
    // The scan keeps a pending address: rd_addr = k_reg, compare when data is back.
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        fetch1_next = fetch1_reg;
        seg_next    = seg_reg;
        rd_addr     = k_reg;
        in_ready    = 1'b0;
        seg_valid   = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
                k_next   = '0;
                if (in_valid && in_mode)
                begin
                    q_next     = $signed(in_qx);
                    n_next     = nclamp;
                    state_next = FE_SCAN;
                    fetch1_next = 1'b0;
                end
            end
            FE_SCAN:
            begin
                // fetch1 low: address k issued last cycle, xrd holds x[k].
                if (!fetch1_reg)
                begin
                    fetch1_next = 1'b1;
                    rd_addr = k_reg;
                end
                else if ($signed(xrd) <= q_reg && !last_k)
                begin
                    k_next  = k_reg + IDX_W'(1);
                    rd_addr = k_reg + IDX_W'(1);
                    fetch1_next = 1'b0;
                end
                else
                begin
                    // Pick upper end of the segment.
                    if (k_reg == '0)
                        k_next = IDX_W'(1);
                    else if ($signed(xrd) <= q_reg)
                        k_next = k_reg;
                    rd_addr     = k_next - IDX_W'(1);
                    fetch1_next = 1'b0;
                    state_next  = FE_FETCH;
                end
            end
            FE_FETCH:
            begin
                // Low end read issued last cycle; issue high end now.
                if (!fetch1_reg)
                begin
                    seg_next.x0 = $signed(xrd);
                    seg_next.y0 = $signed(yrd);
                    rd_addr     = k_reg;
                    fetch1_next = 1'b1;
                end
                else
                begin
                    seg_next.x1 = $signed(xrd);
                    seg_next.y1 = $signed(yrd);
                    seg_next.q  = q_reg;
                    state_next  = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                seg_valid = 1'b1;
                if (seg_ready)
                    state_next = FE_IDLE;
            end
            default:
                state_next = FE_IDLE;
        endcase
    end

    assign seg = seg_reg;

endmodule

>>> hdl/pli_fifo.sv
module pli_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  pli_pkg::seg_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output pli_pkg::seg_t  rd_data
);
    import pli_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    seg_t            slot_reg [QDEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push, pop;

    assign wr_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rp_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

>>> hdl/pli_back.sv
module pli_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seg_valid,
    output logic                          seg_ready,
    input  pli_pkg::seg_t                 seg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pli_pkg::VAL_W-1:0]     out_value,
    output logic [pli_pkg::STAT_W-1:0]    out_status
);
    import pli_pkg::*;

    localparam int BC_W = $clog2(PROD_W + 1);

    be_state_t               state_reg, state_next;
    logic [VAL_W-1:0]        mdy_reg, mdy_next;
    logic [VAL_W-1:0]        mdq_reg, mdq_next;
    logic [VAL_W-1:0]        mw_reg, mw_next;
    logic                    neg_reg, neg_next;
    logic signed [VAL_W-1:0] y0_reg, y0_next;
    logic [PROD_W-1:0]       quo_reg, quo_next;
    logic [VAL_W:0]          rem_reg, rem_next;
    logic [BC_W-1:0]         bc_reg, bc_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [STAT_W-1:0]       st_reg, st_next;

    logic signed [DIFF_W-1:0] dw, dq, dy;
    logic [DIFF_W-1:0]        adw, adq, ady;
    logic [VAL_W:0]           rtry;
    logic [VAL_W+1:0]         rem2;
    logic [PROD_W:0]          qr;
    logic signed [PROD_W+1:0] sum;

    // Segment differences, 33 bits wide.
    always_comb
    begin
        dw  = DIFF_W'(seg.x1) - DIFF_W'(seg.x0);
        dq  = DIFF_W'(seg.q)  - DIFF_W'(seg.x0);
        dy  = DIFF_W'(seg.y1) - DIFF_W'(seg.y0);
        adw = dw[DIFF_W-1] ? DIFF_W'(-dw) : dw;
        adq = dq[DIFF_W-1] ? DIFF_W'(-dq) : dq;
        ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mdy_reg <= mdy_next;
        mdq_reg <= mdq_next;
        mw_reg  <= mw_next;
        neg_reg <= neg_next;
        y0_reg  <= y0_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        bc_reg  <= bc_next;
        val_reg <= val_next;
        st_reg  <= st_next;
    end

    // Restoring divider step and final rounding and saturation.
    always_comb
    begin
        rtry = {rem_reg[VAL_W-1:0], quo_reg[PROD_W-1]};
        rem2 = {rem_reg, 1'b0};
        qr   = {1'b0, quo_reg} + (PROD_W+1)'(rem2 >= (VAL_W+2)'(mw_reg));
        if (qr > (PROD_W+1)'(65'h2_0000_0000))
            sum = neg_reg ? -(PROD_W+2)'(66'sh1_0000_0000)
                          : (PROD_W+2)'(66'sh1_0000_0000);
        else
            sum = (PROD_W+2)'(y0_reg) +
                  (neg_reg ? -$signed((PROD_W+2)'(qr)) : $signed((PROD_W+2)'(qr)));
    end

    always_comb
    begin
        state_next = state_reg;
        mdy_next   = mdy_reg;
        mdq_next   = mdq_reg;
        mw_next    = mw_reg;
        neg_next   = neg_reg;
        y0_next    = y0_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        bc_next    = bc_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        seg_ready  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                seg_ready = 1'b1;
                if (seg_valid)
                begin
                    mdy_next = ady[VAL_W-1:0];
                    mdq_next = adq[VAL_W-1:0];
                    mw_next  = adw[VAL_W-1:0];
                    neg_next = (dy[DIFF_W-1] ^ dq[DIFF_W-1]) ^ dw[DIFF_W-1];
                    y0_next  = seg.y0;
                    if (dw == '0)
                    begin
                        val_next   = '0;
                        st_next    = STAT_DIV;
                        state_next = BE_OUT;
                    end
                    else
                        state_next = BE_MUL;
                end
            end
            BE_MUL:
            begin
                // One 32x32 product, magnitudes below 2^32.
                quo_next   = PROD_W'(mdy_reg) * PROD_W'(mdq_reg);
                rem_next   = '0;
                bc_next    = BC_W'(PROD_W);
                state_next = BE_DIV;
            end
            BE_DIV:
            begin
                if (rtry >= (VAL_W+1)'(mw_reg))
                begin
                    rem_next = rtry - (VAL_W+1)'(mw_reg);
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rtry;
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
                bc_next = bc_reg - BC_W'(1);
                if (bc_reg == BC_W'(1))
                    state_next = BE_ROUND;
            end
            BE_ROUND:
            begin
                if (sum > (PROD_W+2)'(66'sh7FFF_FFFF))
                begin
                    val_next = 32'h7FFF_FFFF;
                    st_next  = STAT_SAT;
                end
                else if (sum < -(PROD_W+2)'(66'sh8000_0000))
                begin
                    val_next = 32'h8000_0000;
                    st_next  = STAT_SAT;
                end
                else
                begin
                    val_next = sum[VAL_W-1:0];
                    st_next  = STAT_OK;
                end
                state_next = BE_OUT;
            end
            BE_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = BE_IDLE;
            end
            default:
                state_next = BE_IDLE;
        endcase
    end

    assign out_value  = val_reg;
    assign out_status = st_reg;

endmodule

>>> hdl/piecewise_linear_interpolator_core.sv
// Channel  | Direction | Contents (lowest bit first)
// s_axis   | in        | tdata: point_index[5:0], point_x, point_y, query_x; tuser: mode
// m_axis   | out       | tdata: curve_value[31:0], status[33:32]
// cfg      | in        | cfg_data: points_in_use[6:0]
// A load item is written to the table as it is accepted. An evaluate item scans
// the breakpoint memory entry by entry until the query's segment is found, then the
// back end runs a multiply step, the divider steps and a rounding step.
// Reset is asynchronous and clears control state only; the table is undefined.
// A two-entry queue lets the scan of the next query proceed while the divider works.
module piecewise_linear_interpolator_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // point_index, point_x, point_y, query_x
    input  logic         s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // curve_value, status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);
    import pli_pkg::*;

    logic [CNT_W-1:0] points_reg;
    logic             fseg_valid, fseg_ready, bseg_valid, bseg_ready;
    seg_t             fseg, bseg;
    logic [VAL_W-1:0] value;
    logic [STAT_W-1:0] status;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            points_reg <= CNT_W'(2);
        else if (cfg_valid)
            points_reg <= cfg_data;
    end

    pli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_index  (s_axis_tdata[5:0]),
        .in_px     (s_axis_tdata[37:6]),
        .in_py     (s_axis_tdata[69:38]),
        .in_qx     (s_axis_tdata[101:70]),
        .points    (points_reg),
        .seg_valid (fseg_valid),
        .seg_ready (fseg_ready),
        .seg       (fseg)
    );

    pli_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fseg_valid),
        .wr_ready (fseg_ready),
        .wr_data  (fseg),
        .rd_valid (bseg_valid),
        .rd_ready (bseg_ready),
        .rd_data  (bseg)
    );

    pli_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (bseg_valid),
        .seg_ready  (bseg_ready),
        .seg        (bseg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (value),
        .out_status (status)
    );

    assign m_axis_tdata = {6'd0, status, value};

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Status never takes the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status == STAT_OK || status == STAT_SAT || status == STAT_DIV))
        else $error("bad status");

    // A zero-width segment always reports a zero value.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == STAT_DIV |-> value == '0)
        else $error("divide-by-zero value not zero");

endmodule
